[rtl/sorted_table_insert_delete_assert.svh]
// Assertion macros for the sorted table block.
`ifndef SORTED_TABLE_INSERT_DELETE_ASSERT_SVH
`define SORTED_TABLE_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTH
`define STID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sorted table assertion failed");
`define STID_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("sorted table assertion failed");
`else
`define STID_ASSERT(lbl, prop)
`define STID_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/stid_pkg.sv]
// Shared constants and types for the sorted table block.
`default_nettype none

package stid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;

    localparam int OUT_BITS    = STAT_W + IDX_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]  entry_count;
        logic [IDX_W-1:0]  position;
        logic [STAT_W-1:0] status;
    } res_t;

endpackage

`default_nettype wire

[rtl/stid_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module stid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/stid_seq.sv]
// Sequencer: scans the table RAM, shifts entries and keeps the entry count.
`default_nettype none

`include "sorted_table_insert_delete_assert.svh"

module stid_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_kind,
    input  wire logic [stid_pkg::VAL_W-1:0]  in_value,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output stid_pkg::res_t                   res,
    output logic                             mem_we,
    output logic      [stid_pkg::IDX_W-1:0]  mem_waddr,
    output logic      [stid_pkg::VAL_W-1:0]  mem_wdata,
    output logic      [stid_pkg::IDX_W-1:0]  mem_raddr,
    input  wire logic [stid_pkg::VAL_W-1:0]  mem_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WRV  = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [stid_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                          kind_reg, kind_next;
    logic [stid_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [stid_pkg::CNT_W-1:0]    n_reg, n_next;
    logic [stid_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [stid_pkg::IDX_W-1:0]    pos_reg, pos_next;
    logic                          found_reg, found_next;
    logic [stid_pkg::STAT_W-1:0]   status_reg, status_next;

    logic rd_less;
    logic rd_hit;
    logic at_last;

    assign rd_less = $signed(mem_rdata) < $signed(val_reg);
    assign rd_hit  = !found_reg && (mem_rdata == val_reg);
    assign at_last = stid_pkg::CNT_W'(idx_reg) == (n_reg - stid_pkg::CNT_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg + stid_pkg::IDX_W'(1);
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg - stid_pkg::IDX_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next   = in_kind;
                    val_next    = in_value;
                    n_next      = count_reg;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    status_next = stid_pkg::ST_DONE;
                    if (in_kind == stid_pkg::KIND_INSERT)
                    begin
                        if (count_reg == stid_pkg::CNT_W'(stid_pkg::CAPACITY))
                        begin
                            status_next = stid_pkg::ST_FULL;
                            state_next  = S_RES;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_WRV;
                        end
                        else
                        begin
                            mem_raddr  = stid_pkg::IDX_W'(count_reg - stid_pkg::CNT_W'(1));
                            idx_next   = mem_raddr;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = stid_pkg::ST_NOT_FOUND;
                            state_next  = S_RES;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (kind_reg == stid_pkg::KIND_INSERT)
                begin
                    // walk down from the top, moving entries >= value up one slot
                    mem_we = 1'b1;
                    if (!rd_less)
                    begin
                        if (idx_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = S_WRV;
                        end
                        else
                        begin
                            idx_next = idx_reg - stid_pkg::IDX_W'(1);
                        end
                    end
                    else
                    begin
                        mem_wdata   = val_reg;
                        pos_next    = idx_reg + stid_pkg::IDX_W'(1);
                        count_next  = n_reg + stid_pkg::CNT_W'(1);
                        status_next = stid_pkg::ST_DONE;
                        state_next  = S_RES;
                    end
                end
                else
                begin
                    // walk up; after the hit every entry moves down one slot
                    mem_waddr = idx_reg - stid_pkg::IDX_W'(1);
                    mem_we    = found_reg;
                    if (rd_hit)
                    begin
                        found_next = 1'b1;
                        pos_next   = idx_reg;
                    end
                    if (at_last)
                    begin
                        if (found_reg || rd_hit)
                        begin
                            status_next = stid_pkg::ST_DONE;
                            count_next  = n_reg - stid_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            status_next = stid_pkg::ST_NOT_FOUND;
                        end
                        state_next = S_RES;
                    end
                    else
                    begin
                        mem_raddr = idx_reg + stid_pkg::IDX_W'(1);
                        idx_next  = mem_raddr;
                    end
                end
            end

            S_WRV:
            begin
                mem_we      = 1'b1;
                mem_waddr   = pos_reg;
                mem_wdata   = val_reg;
                count_next  = n_reg + stid_pkg::CNT_W'(1);
                status_next = stid_pkg::ST_DONE;
                state_next  = S_RES;
            end

            S_RES:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.position    = pos_reg;
    assign res.entry_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        n_reg      <= n_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    `STID_ASSERT(a_count_bound, count_reg <= stid_pkg::CNT_W'(stid_pkg::CAPACITY))
    `STID_ASSERT(a_no_write_idle, (state_reg == S_IDLE || state_reg == S_RES) |-> !mem_we)
    `STID_ASSERT(a_insert_room, (state_reg == S_SCAN && kind_reg == stid_pkg::KIND_INSERT) |-> (n_reg < stid_pkg::CNT_W'(stid_pkg::CAPACITY)))
    `STID_ASSERT(a_pos_in_range, (res_valid && res.status == stid_pkg::ST_DONE) |-> (stid_pkg::CNT_W'(res.position) <= res.entry_count))
    `STID_ASSERT(a_count_hold, (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))

endmodule

`default_nettype wire

[rtl/sorted_table_insert_delete.sv]
// Top level: sorted table with insert and delete over stream ports.
// Timing: an insert scans the entries at or above the new value, a delete scans every
//   entry, and a full insert or empty delete goes straight to the result state.
// Throughput: one beat at a time, taken only when idle; scans are set by the single RAM read per cycle.
// Reset: rst_n asynchronous active low clears the entry count and handshake state;
//   table RAM contents are left as they are and never read before being written.
`default_nettype none

module sorted_table_insert_delete (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [stid_pkg::VAL_W-1:0]        s_axis_tdata,   // value
    input  wire logic [0:0]                        s_axis_tuser,   // kind
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic      [stid_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // status, position, entry_count
);

    logic                         res_valid;
    logic                         res_ready;
    stid_pkg::res_t               res;
    logic                         mem_we;
    logic [stid_pkg::IDX_W-1:0]   mem_waddr;
    logic [stid_pkg::VAL_W-1:0]   mem_wdata;
    logic [stid_pkg::IDX_W-1:0]   mem_raddr;
    logic [stid_pkg::VAL_W-1:0]   mem_rdata;

    logic                              out_valid_reg, out_valid_next;
    logic [stid_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    stid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser[0]),
        .in_value  (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    stid_ram #(
        .WIDTH (stid_pkg::VAL_W),
        .DEPTH (stid_pkg::CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = stid_pkg::OUT_TDATA_W'(res);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the sorted table block: directed and random insert/delete beats.
`timescale 1ns / 100ps

module tb;

    localparam int IDLE_PCT       = 7;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [stid_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [stid_pkg::VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [stid_pkg::VAL_W-1:0]       s_axis_tdata;   // value
    logic [0:0]                       s_axis_tuser;   // kind
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [stid_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // status, position, entry_count

    logic signed [stid_pkg::VAL_W-1:0] table_vals [stid_pkg::CAPACITY];
    int                                table_len;
    stid_pkg::res_t                    pending_results [$];
    int                                mismatch_count;
    int                                idle_cycles;
    bit                                idle_on;

    sorted_table_insert_delete dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Updates the table copy and returns the result the block should produce.
    function automatic stid_pkg::res_t apply_table_op(
        input logic op_kind,
        input logic signed [stid_pkg::VAL_W-1:0] op_value);
        stid_pkg::res_t r;
        int             i;
        r.status   = stid_pkg::ST_DONE;
        r.position = '0;
        i = 0;
        if (op_kind == stid_pkg::KIND_INSERT)
        begin
            if (table_len >= stid_pkg::CAPACITY)
                r.status = stid_pkg::ST_FULL;
            else
            begin
                while (i < table_len && table_vals[i] < op_value)
                    i++;
                for (int j = table_len; j > i; j--)
                    table_vals[j] = table_vals[j-1];
                table_vals[i] = op_value;
                table_len++;
                r.position = i[stid_pkg::IDX_W-1:0];
            end
        end
        else
        begin
            while (i < table_len && table_vals[i] != op_value)
                i++;
            if (i >= table_len)
                r.status = stid_pkg::ST_NOT_FOUND;
            else
            begin
                for (int j = i; j + 1 < table_len; j++)
                    table_vals[j] = table_vals[j+1];
                table_len--;
                r.position = i[stid_pkg::IDX_W-1:0];
            end
        end
        r.entry_count = table_len[stid_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic op_kind, input logic [stid_pkg::VAL_W-1:0] op_value);
        while (idle_on && $urandom_range(99, 0) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= op_value;
        s_axis_tuser  <= op_kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_table_op(op_kind, op_value));
    endtask

    // Values cluster in a small range so duplicates and delete hits are common.
    function automatic logic [stid_pkg::VAL_W-1:0] pick_value(input logic op_kind);
        int sel;
        sel = $urandom_range(99, 0);
        if (op_kind == stid_pkg::KIND_DELETE && table_len > 0 && sel < 70)
            return table_vals[$urandom_range(table_len - 1, 0)];
        sel = $urandom_range(99, 0);
        if (sel < 50)
            return $urandom_range(20, 0) - 10;
        if (sel < 60)
        begin
            case ($urandom_range(5, 0))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX;
                3: return VAL_MAX - 1;
                4: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_empty_table();
        send_item(stid_pkg::KIND_DELETE, 32'd5);
        send_item(stid_pkg::KIND_DELETE, VAL_MIN);
    endtask

    task automatic test_extremes_and_duplicates();
        send_item(stid_pkg::KIND_INSERT, '0);
        send_item(stid_pkg::KIND_INSERT, VAL_MAX);
        send_item(stid_pkg::KIND_INSERT, VAL_MIN);
        send_item(stid_pkg::KIND_INSERT, '1);
        send_item(stid_pkg::KIND_INSERT, '0);
        send_item(stid_pkg::KIND_INSERT, VAL_MAX);
        send_item(stid_pkg::KIND_DELETE, '0);
        send_item(stid_pkg::KIND_DELETE, 32'd123);
    endtask

    task automatic test_fill_to_full();
        while (table_len < stid_pkg::CAPACITY)
            send_item(stid_pkg::KIND_INSERT, $urandom_range(40, 0) - 20);
        send_item(stid_pkg::KIND_INSERT, VAL_MIN);
        send_item(stid_pkg::KIND_INSERT, VAL_MAX);
        send_item(stid_pkg::KIND_DELETE, 32'h5555_AAAA);
    endtask

    task automatic test_delete_positions();
        send_item(stid_pkg::KIND_DELETE, table_vals[table_len - 1]);
        send_item(stid_pkg::KIND_DELETE, table_vals[0]);
        send_item(stid_pkg::KIND_DELETE, table_vals[table_len / 2]);
    endtask

    task automatic test_random_mix();
        int   insert_pct;
        logic op_kind;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // a long run with no gaps on either side
            idle_on = !(n >= 400 && n < 700);
            case ((n / 100) % 3)
                0: insert_pct = 75;
                1: insert_pct = 30;
                default: insert_pct = 55;
            endcase
            op_kind = ($urandom_range(99, 0) < insert_pct) ? stid_pkg::KIND_INSERT
                                                           : stid_pkg::KIND_DELETE;
            send_item(op_kind, pick_value(op_kind));
        end
        idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= idle_on ? ($urandom_range(99, 0) >= IDLE_PCT) : 1'b1;
    end

    always @(posedge clk)
    begin
        stid_pkg::res_t expected_res;
        stid_pkg::res_t got_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = stid_pkg::res_t'(m_axis_tdata[stid_pkg::OUT_BITS-1:0]);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: tdata %h", m_axis_tdata);
            end
            else
            begin
                expected_res = pending_results.pop_front();
                if (got_res.status != expected_res.status
                    || got_res.position != expected_res.position
                    || got_res.entry_count != expected_res.entry_count
                    || (m_axis_tdata >> stid_pkg::OUT_BITS) != 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected status %0d pos %0d count %0d, ",
                                  "got status %0d pos %0d count %0d (tdata %h)"},
                                 expected_res.status, expected_res.position,
                                 expected_res.entry_count, got_res.status,
                                 got_res.position, got_res.entry_count, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= '0;
        m_axis_tready  <= 1'b0;
        idle_cycles    = 0;
        mismatch_count = 0;
        table_len      = 0;
        idle_on        = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_extremes_and_duplicates();
        test_fill_to_full();
        test_delete_positions();
        test_random_mix();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (stid_pkg::CAPACITY + 8) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sorted_table_insert_delete.f]
+incdir+rtl
rtl/stid_pkg.sv
rtl/stid_ram.sv
rtl/stid_seq.sv
rtl/sorted_table_insert_delete.sv
tb/tb.sv
